// File: design/rprop_pkg.sv
package rprop_pkg;

  localparam int STEP_BITS     = 31;
  localparam int FACTOR_BITS   = 16;
  localparam int FACTOR_SHIFT  = 14;
  localparam int DZ_BITS       = 16;
  localparam int CFG_ADDR_BITS = 8;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [STEP_BITS-1:0]   STEP_MIN_RST    = 31'd1;
  localparam logic [STEP_BITS-1:0]   STEP_MAX_RST    = 31'd838860800;
  localparam logic [FACTOR_BITS-1:0] STEP_GROW_RST   = 16'd19661;
  localparam logic [FACTOR_BITS-1:0] STEP_SHRINK_RST = 16'd8192;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_BACKTRACK   = 8'd0,
    CFG_STEP_MIN    = 8'd1,
    CFG_STEP_MAX    = 8'd2,
    CFG_STEP_GROW   = 8'd3,
    CFG_STEP_SHRINK = 8'd4,
    CFG_L1_WEIGHT   = 8'd5,
    CFG_L1_CUTOFF   = 8'd6,
    CFG_DEAD_ZONE   = 8'd7
  } cfg_addr_e;

  typedef struct packed {
    logic                   backtrack_mode;
    logic [STEP_BITS-1:0]   step_min;
    logic [STEP_BITS-1:0]   step_max;
    logic [FACTOR_BITS-1:0] step_grow;
    logic [FACTOR_BITS-1:0] step_shrink;
    logic [STEP_BITS-1:0]   l1_weight;
    logic                   l1_cutoff;
    logic [DZ_BITS-1:0]     dead_zone;
  } rprop_cfg_t;

endpackage

// File: design/rprop_cfg_regs.sv
module rprop_cfg_regs
  import rprop_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output rprop_cfg_t               cfg_o
);

  rprop_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_BACKTRACK:   cfg_d.backtrack_mode = cfg_data_i[0];
        CFG_STEP_MIN:    cfg_d.step_min       = cfg_data_i[STEP_BITS-1:0];
        CFG_STEP_MAX:    cfg_d.step_max       = cfg_data_i[STEP_BITS-1:0];
        CFG_STEP_GROW:   cfg_d.step_grow      = cfg_data_i[FACTOR_BITS-1:0];
        CFG_STEP_SHRINK: cfg_d.step_shrink    = cfg_data_i[FACTOR_BITS-1:0];
        CFG_L1_WEIGHT:   cfg_d.l1_weight      = cfg_data_i[STEP_BITS-1:0];
        CFG_L1_CUTOFF:   cfg_d.l1_cutoff      = cfg_data_i[0];
        CFG_DEAD_ZONE:   cfg_d.dead_zone      = cfg_data_i[DZ_BITS-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backtrack_mode <= 1'b1;
      cfg_q.step_min       <= STEP_MIN_RST;
      cfg_q.step_max       <= STEP_MAX_RST;
      cfg_q.step_grow      <= STEP_GROW_RST;
      cfg_q.step_shrink    <= STEP_SHRINK_RST;
      cfg_q.l1_weight      <= '0;
      cfg_q.l1_cutoff      <= 1'b0;
      cfg_q.dead_zone      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: design/rprop_update_core.sv
module rprop_update_core
  import rprop_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  rprop_cfg_t                     cfg_i,
  input  logic signed [VALUE_BITS-1:0]   weight_i,
  input  logic signed [VALUE_BITS-1:0]   gradient_i,
  input  logic signed [VALUE_BITS-1:0]   prior_weight_i,
  input  logic        [STEP_BITS-1:0]    step_size_i,
  input  logic signed [VALUE_BITS-1:0]   prior_gradient_i,
  output logic signed [VALUE_BITS-1:0]   new_weight_o,
  output logic signed [VALUE_BITS-1:0]   new_prior_weight_o,
  output logic        [STEP_BITS-1:0]    new_step_size_o,
  output logic signed [VALUE_BITS-1:0]   new_prior_gradient_o,
  output logic                           saturated_o
);

  localparam int EW   = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 3;
  localparam int PW   = STEP_BITS + FACTOR_BITS;
  localparam int SCW  = PW - FACTOR_SHIFT;

  typedef logic signed [EW-1:0] ext_t;
  typedef struct packed {
    logic neg;
    logic pos;
  } sgn_t;

  localparam ext_t VMAX = (ext_t'(1) <<< (VALUE_BITS - 1)) - ext_t'(1);
  localparam ext_t VMIN = -VMAX - ext_t'(1);

  function automatic sgn_t dz_sign(ext_t v, ext_t dz);
    sgn_t s;
    s.neg = (v < -dz);
    s.pos = (v > dz);
    return s;
  endfunction

  function automatic ext_t clamp(ext_t v);
    ext_t r;
    r = v;
    if (v > VMAX) r = VMAX;
    else if (v < VMIN) r = VMIN;
    return r;
  endfunction

  ext_t x, g, xp, gp, rho, dz;
  ext_t pg_raw, pg, sum;
  sgn_t sx, sg, spg, sgp;
  logic wbt, l1_on, orth, cutm, in_band, cut;
  logic prod_pos, prod_neg, add_pos, add_neg;
  logic [PW-1:0]        grow_p, shrink_p;
  logic [SCW-1:0]       grow_sc, shrink_sc;
  logic [STEP_BITS-1:0] grow_st, shrink_st, stp_new;

  assign x    = ext_t'(weight_i);
  assign g    = ext_t'(gradient_i);
  assign xp   = ext_t'(prior_weight_i);
  assign gp   = ext_t'(prior_gradient_i);
  assign rho  = ext_t'(cfg_i.l1_weight);
  assign dz   = ext_t'(cfg_i.dead_zone);

  assign wbt   = cfg_i.backtrack_mode;
  assign l1_on = (cfg_i.l1_weight != '0);
  assign orth  = l1_on && !cfg_i.l1_cutoff;
  assign cutm  = l1_on && cfg_i.l1_cutoff;

  assign sx = dz_sign(x, dz);

  // orthant pseudo gradient; only its sign is used further on
  always_comb begin
    if (sx.neg)       pg_raw = g - rho;
    else if (sx.pos)  pg_raw = g + rho;
    else if (g < -rho) pg_raw = g + rho;
    else if (g > rho) pg_raw = g - rho;
    else              pg_raw = '0;
  end

  assign pg  = orth ? clamp(pg_raw) : g;
  assign spg = dz_sign(pg, dz);
  assign sg  = dz_sign(g, dz);
  assign sgp = dz_sign(gp, dz);

  always_comb begin
    if (sx.pos)      in_band = (g < 0) && (g > -(rho <<< 1));
    else if (sx.neg) in_band = (g > 0) && (g < (rho <<< 1));
    else             in_band = (g > -rho) && (g < rho);
  end

  assign cut = cutm && in_band &&
               ((x == 0) ||
                ((((gp < 0) && (g > 0)) || ((gp > 0) && (g < 0))) &&
                 (((xp < 0) && (x > 0)) || ((xp > 0) && (x < 0)))));

  assign prod_pos = (sgp.pos && spg.pos) || (sgp.neg && spg.neg);
  assign prod_neg = (sgp.pos && spg.neg) || (sgp.neg && spg.pos);

  // both scaled steps in parallel, chosen by the sign product
  assign grow_p    = PW'(step_size_i) * PW'(cfg_i.step_grow);
  assign shrink_p  = PW'(step_size_i) * PW'(cfg_i.step_shrink);
  assign grow_sc   = grow_p[PW-1:FACTOR_SHIFT];
  assign shrink_sc = shrink_p[PW-1:FACTOR_SHIFT];

  always_comb begin
    grow_st = (grow_sc[SCW-1:STEP_BITS] != '0) ? '1 : grow_sc[STEP_BITS-1:0];
    if (grow_st > cfg_i.step_max) grow_st = cfg_i.step_max;
    shrink_st = (shrink_sc[SCW-1:STEP_BITS] != '0) ? '1 : shrink_sc[STEP_BITS-1:0];
    if (shrink_st < cfg_i.step_min) shrink_st = cfg_i.step_min;
  end

  assign stp_new = prod_pos ? grow_st : (prod_neg ? shrink_st : step_size_i);

  always_comb begin
    new_weight_o         = weight_i;
    new_prior_weight_o   = prior_weight_i;
    new_step_size_o      = step_size_i;
    new_prior_gradient_o = gradient_i;
    add_pos              = 1'b0;
    add_neg              = 1'b0;
    sum                  = x;
    saturated_o          = 1'b0;
    if (cut) begin
      new_weight_o = '0;
      if (wbt) new_prior_weight_o = weight_i;
    end else begin
      new_step_size_o = stp_new;
      if (!wbt || prod_pos) begin
        // move against the gradient; orthant mode moves only against the pseudo gradient
        if (orth) begin
          add_pos = sg.pos ? 1'b0 : (sg.neg && spg.neg);
          add_neg = sg.pos && spg.pos;
        end else begin
          add_pos = sg.neg;
          add_neg = sg.pos;
        end
        if (wbt) new_prior_weight_o = weight_i;
      end else if (prod_neg) begin
        // backtrack to the saved weight
        new_weight_o         = prior_weight_i;
        new_prior_gradient_o = '0;
      end else begin
        new_prior_weight_o = weight_i;
        if (!orth) begin
          add_pos = spg.neg;
          add_neg = spg.pos;
        end
      end
      if (!wbt || !prod_neg) begin
        if (add_pos)      sum = x + ext_t'(stp_new);
        else if (add_neg) sum = x - ext_t'(stp_new);
        saturated_o  = (sum > VMAX) || (sum < VMIN);
        new_weight_o = VALUE_BITS'(clamp(sum));
      end
    end
  end

endmodule

// File: design/rprop_weight_update.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o    weight, gradient, prior_weight, step_size,
//                                                prior_gradient
// out      output     out_valid_o / out_stall_i  new_weight, new_prior_weight, new_step_size,
//                                                new_prior_gradient, saturated
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_addr_i, cfg_data_i
//
// One weight per cycle while in_stall_o is low; each accepted beat passes through:
// an input register, one pass through the update datapath (step multiply, then the
// saturating weight add), and the result register.
// Reset clears both valid flags and loads the register defaults; no clearing pass.
// A stalled result holds in the output register while one more beat waits in the input
// register; in_stall_o rises only when both are full and out_stall_i is high.
// cfg_ready_o is always high.
module rprop_weight_update
  import rprop_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic        [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic        [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [VALUE_BITS-1:0]   weight_i,
  input  logic signed [VALUE_BITS-1:0]   gradient_i,
  input  logic signed [VALUE_BITS-1:0]   prior_weight_i,
  input  logic        [STEP_BITS-1:0]    step_size_i,
  input  logic signed [VALUE_BITS-1:0]   prior_gradient_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [VALUE_BITS-1:0]   new_weight_o,
  output logic signed [VALUE_BITS-1:0]   new_prior_weight_o,
  output logic        [STEP_BITS-1:0]    new_step_size_o,
  output logic signed [VALUE_BITS-1:0]   new_prior_gradient_o,
  output logic                           saturated_o
);

  rprop_cfg_t cfg;

  logic                         s1_valid_q, s1_valid_d;
  logic                         out_valid_q, out_valid_d;
  logic                         advance, in_take;
  logic signed [VALUE_BITS-1:0] w_q, g_q, wp_q, gp_q;
  logic        [STEP_BITS-1:0]  st_q;

  logic signed [VALUE_BITS-1:0] nw, nwp, ngp;
  logic        [STEP_BITS-1:0]  nst;
  logic                         nsat;

  logic signed [VALUE_BITS-1:0] nw_q, nwp_q, ngp_q;
  logic        [STEP_BITS-1:0]  nst_q;
  logic                         nsat_q;

  rprop_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rprop_update_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .cfg_i                (cfg),
    .weight_i             (w_q),
    .gradient_i           (g_q),
    .prior_weight_i       (wp_q),
    .step_size_i          (st_q),
    .prior_gradient_i     (gp_q),
    .new_weight_o         (nw),
    .new_prior_weight_o   (nwp),
    .new_step_size_o      (nst),
    .new_prior_gradient_o (ngp),
    .saturated_o          (nsat)
  );

  // advance the input stage whenever the result register is free or being taken
  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_stall_o ? s1_valid_q : in_valid_i;
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      w_q  <= weight_i;
      g_q  <= gradient_i;
      wp_q <= prior_weight_i;
      st_q <= step_size_i;
      gp_q <= prior_gradient_i;
    end
    if (advance && s1_valid_q) begin
      nw_q   <= nw;
      nwp_q  <= nwp;
      nst_q  <= nst;
      ngp_q  <= ngp;
      nsat_q <= nsat;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign new_weight_o         = nw_q;
  assign new_prior_weight_o   = nwp_q;
  assign new_step_size_o      = nst_q;
  assign new_prior_gradient_o = ngp_q;
  assign saturated_o          = nsat_q;

endmodule
